// ===== src/polyline_train_placer_defines.svh =====
// Assertion macros for the polyline train placer.
`ifndef POLYLINE_TRAIN_PLACER_DEFINES_SVH
`define POLYLINE_TRAIN_PLACER_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define PTP_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PTP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define PTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ptp_pkg.sv =====
// Shared types, constants and tables of the polyline train placer.
package ptp_pkg;

  localparam int COORD_W = 24;
  localparam int DIST_W = 32;
  localparam int D_W = 33;
  localparam int DELTA_W = 25;
  localparam int ANG_W = 16;
  localparam int PITCH_W = 24;
  localparam int WCNT_W = 5;
  localparam int IDX_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam int DEF_MAX_VERTICES = 256;
  localparam int DEF_MAX_WAGONS = 16;

  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_W = 34;
  localparam int ZANG_W = 25;
  localparam logic [31:0] ARC_MAX = 32'h7FFF_FFFF;
  localparam logic signed [ZANG_W-1:0] DEG90_Q16 = 25'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG90_Q7 = 16'sd11520;
  localparam logic signed [ANG_W-1:0] DEG180_Q7 = 16'sd23040;

  localparam logic [CFG_IDX_W-1:0] CFG_WAGON_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAGON_PITCH = 2'd1;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_PLACE  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef struct packed {
    logic                      start;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
  } cordic_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ANG_W-1:0] angle;
  } cordic_rsp_t;

  // Arctangent of 2^-k in degrees, Q16.
  function automatic logic [22:0] atan_deg_q16(input logic [4:0] k);
    logic [22:0] v;
    case (k)
      5'd0:  v = 23'd2949120;
      5'd1:  v = 23'd1740967;
      5'd2:  v = 23'd919879;
      5'd3:  v = 23'd466945;
      5'd4:  v = 23'd234379;
      5'd5:  v = 23'd117304;
      5'd6:  v = 23'd58666;
      5'd7:  v = 23'd29335;
      5'd8:  v = 23'd14668;
      5'd9:  v = 23'd7334;
      5'd10: v = 23'd3667;
      5'd11: v = 23'd1833;
      5'd12: v = 23'd917;
      5'd13: v = 23'd458;
      5'd14: v = 23'd229;
      5'd15: v = 23'd115;
      5'd16: v = 23'd57;
      5'd17: v = 23'd29;
      5'd18: v = 23'd14;
      5'd19: v = 23'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/ptp_if.sv =====
// Channel interfaces of the polyline train placer.
interface ptp_in_if
  import ptp_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [DIST_W-1:0]  head_distance;

  modport source (output valid, func, pos_x, pos_y, head_distance, input ready);
  modport sink (input valid, func, pos_x, pos_y, head_distance, output ready);
endinterface

interface ptp_out_if
  import ptp_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [IDX_W-1:0]          wagon_index;
  logic signed [COORD_W-1:0] wagon_x;
  logic signed [COORD_W-1:0] wagon_y;
  logic signed [ANG_W-1:0]   angle;
  logic                      empty_res;
  logic                      last;

  modport source (output valid, wagon_index, wagon_x, wagon_y, angle, empty_res, last,
                  input ready);
  modport sink (input valid, wagon_index, wagon_x, wagon_y, angle, empty_res, last,
                output ready);
endinterface

interface ptp_cfg_if
  import ptp_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/ptp_cordic.sv =====
// Iterative vectoring CORDIC that gives a segment direction in degrees.
module ptp_cordic
  import ptp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cordic_req_t req_i,
  output cordic_rsp_t rsp_o
);

  logic                       busy_q, fin_q, done_q;
  logic signed [CORDIC_W-1:0] x_q, y_q, xs, ys;
  logic signed [ZANG_W-1:0]   z_q, zc;
  logic signed [ZANG_W-1:0]   at;
  logic [4:0]                 k_q;
  logic                       negx_q, negy_q;
  logic signed [ANG_W-1:0]    ang_q, a_fin;
  logic [ZANG_W-1:0]          zr;
  logic [DELTA_W-2:0]         adx, ady;

  assign adx = req_i.dx[DELTA_W-1] ? (DELTA_W-1)'(-req_i.dx) : req_i.dx[DELTA_W-2:0];
  assign ady = req_i.dy[DELTA_W-1] ? (DELTA_W-1)'(-req_i.dy) : req_i.dy[DELTA_W-2:0];
  assign xs = x_q >>> k_q;
  assign ys = y_q >>> k_q;
  assign at = $signed({2'b00, atan_deg_q16(k_q)});

  always_comb begin
    if (z_q < 0) begin
      zc = '0;
    end else if (z_q > DEG90_Q16) begin
      zc = DEG90_Q16;
    end else begin
      zc = z_q;
    end
    zr = (ZANG_W)'(zc + 25'sd256) >> 9;
    a_fin = $signed(zr[ANG_W-1:0]);
    if (negx_q) begin
      a_fin = DEG180_Q7 - a_fin;
    end
    if (negy_q) begin
      a_fin = -a_fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      fin_q <= 1'b0;
      if (req_i.dy == '0 || req_i.dx == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
      end
    end else if (busy_q) begin
      if (k_q == 5'(CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
        fin_q  <= 1'b1;
      end
    end else if (fin_q) begin
      fin_q  <= 1'b0;
      done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      negx_q <= req_i.dx[DELTA_W-1];
      negy_q <= req_i.dy[DELTA_W-1];
      x_q    <= $signed(CORDIC_W'(adx) << 6);
      y_q    <= $signed(CORDIC_W'(ady) << 6);
      z_q    <= '0;
      k_q    <= '0;
      if (req_i.dy == '0) begin
        ang_q <= req_i.dx[DELTA_W-1] ? DEG180_Q7 : '0;
      end else if (req_i.dx == '0) begin
        ang_q <= req_i.dy[DELTA_W-1] ? -DEG90_Q7 : DEG90_Q7;
      end
    end else if (busy_q) begin
      if (!y_q[CORDIC_W-1]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end
      k_q <= k_q + 5'd1;
    end else if (fin_q) begin
      ang_q <= a_fin;
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.angle = ang_q;

endmodule

// ===== src/polyline_train_placer.sv =====
// Top level of the polyline train placer: path store, sequencer and arithmetic.
//
// Channels: in_i takes transactions that clear the path, append a vertex or place
// the train; out_o gives one transaction per wagon of a place request, the last one
// flagged; cfg_i writes wagon_count (index 0) and wagon_pitch (index 1).
// A clear acts in the idle state; an append does two squares on the shared
// multiplier, a 25-step square root and one store write. A place request does, per
// wagon, one memory read and compare for each segment passed in the arc length
// search, then, unless the offset or segment length is zero, two 57-step restoring
// divisions that share one subtractor; the 20-step CORDIC for the angle runs
// alongside them. An empty path gives one result straight from the idle state.
// The block takes one transaction at a time and is not ready while it works.
// Results leave through an output register, so the next wagon is computed while a
// result waits; when the receiver stalls, the block holds with the next result.
// Reset empties the path and sets wagon_count to 1 and wagon_pitch to 0; the
// vertex memories need no clearing.
`include "polyline_train_placer_defines.svh"

module polyline_train_placer
  import ptp_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_WAGONS   = DEF_MAX_WAGONS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptp_cfg_if.sink   cfg_i,
  ptp_in_if.sink    in_i,
  ptp_out_if.source out_o
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int CW = $clog2(MAX_WAGONS + 1);
  localparam int PROD_W = DELTA_W + D_W;
  localparam int DQ_W = 57;
  localparam int SQ_W = 49;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_AMULX  = 5'd1;
  localparam logic [4:0] ST_AMULY  = 5'd2;
  localparam logic [4:0] ST_ASQLD  = 5'd3;
  localparam logic [4:0] ST_ASQRT  = 5'd4;
  localparam logic [4:0] ST_AWR    = 5'd5;
  localparam logic [4:0] ST_PSTART = 5'd6;
  localparam logic [4:0] ST_SINGLE = 5'd7;
  localparam logic [4:0] ST_SEARCH = 5'd8;
  localparam logic [4:0] ST_SCMP   = 5'd9;
  localparam logic [4:0] ST_FETCH1 = 5'd10;
  localparam logic [4:0] ST_FETCH0 = 5'd11;
  localparam logic [4:0] ST_CALC   = 5'd12;
  localparam logic [4:0] ST_SETUP  = 5'd13;
  localparam logic [4:0] ST_MUL    = 5'd14;
  localparam logic [4:0] ST_DLOAD  = 5'd15;
  localparam logic [4:0] ST_DIV    = 5'd16;
  localparam logic [4:0] ST_DEND   = 5'd17;
  localparam logic [4:0] ST_WANG   = 5'd18;
  localparam logic [4:0] ST_OUT    = 5'd19;

  logic [4:0] state_q, state_d;
  logic [NW-1:0] n_q;
  logic [WCNT_W-1:0] wcount_q;
  logic [PITCH_W-1:0] pitch_q;
  logic out_valid_q;

  logic signed [COORD_W-1:0] x_mem [MAX_VERTICES];
  logic signed [COORD_W-1:0] y_mem [MAX_VERTICES];
  logic [DIST_W-1:0] arc_mem [MAX_VERTICES];
  logic [AW-1:0] rd_addr;
  logic wr_en;
  logic signed [COORD_W-1:0] rd_x_q, rd_y_q;
  logic [DIST_W-1:0] rd_arc_q;

  logic signed [COORD_W-1:0] ax_q, ay_q, last_x_q, last_y_q;
  logic [DIST_W-1:0] total_q, arc_new;
  logic signed [DELTA_W-1:0] app_dx, app_dy;
  logic signed [DELTA_W-1:0] mul_a;
  logic signed [D_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod, prod_q;
  logic [SQ_W-1:0] sq_q, rad_q, sbit_q, sres_q;
  logic [SQ_W:0] strial;
  logic [D_W-1:0] arc_sum;

  logic signed [D_W-1:0] d_q, tot33, head33;
  logic [CW-1:0] k_q, cnt_q;
  logic is_last;
  logic [AW-1:0] i_q, i_end;
  logic signed [COORD_W-1:0] x1_q, y1_q, s_x_q, s_y_q;
  logic [DIST_W-1:0] a1_q;
  logic signed [DELTA_W-1:0] ddx_q, ddy_q;
  logic [30:0] seg_q, rem_q;
  logic signed [D_W-1:0] off_q;
  logic axis_q, neg_q;
  logic [DQ_W-1:0] quo_q;
  logic [5:0] dcnt_q;
  logic [31:0] dtrial;
  logic dge;
  logic [PROD_W-1:0] prod_abs;
  logic signed [DQ_W+1:0] pos_sum;
  logic signed [COORD_W-1:0] pos_sat;

  logic signed [COORD_W-1:0] res_x_q, res_y_q;
  logic signed [ANG_W-1:0] res_ang_q;
  logic res_empty_q;
  logic out_load;

  cordic_req_t cordic_req;
  cordic_rsp_t cordic_rsp;

  ptp_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cordic_req),
    .rsp_o  (cordic_rsp)
  );

  assign cordic_req.start = (state_q == ST_SETUP);
  assign cordic_req.dx    = ddx_q;
  assign cordic_req.dy    = ddy_q;

  assign app_dx = {ax_q[COORD_W-1], ax_q} - {last_x_q[COORD_W-1], last_x_q};
  assign app_dy = {ay_q[COORD_W-1], ay_q} - {last_y_q[COORD_W-1], last_y_q};
  assign prod = mul_a * mul_b;
  assign strial = {1'b0, sres_q} + {1'b0, sbit_q};
  assign arc_sum = {1'b0, total_q} + D_W'(sres_q);
  assign arc_new = (n_q == '0) ? '0 :
                   (arc_sum > {1'b0, ARC_MAX}) ? ARC_MAX : arc_sum[DIST_W-1:0];
  assign tot33 = $signed({1'b0, total_q});
  assign head33 = $signed({in_i.head_distance[DIST_W-1], in_i.head_distance});
  assign i_end = AW'(n_q - NW'(2));
  assign is_last = (k_q + CW'(1)) == cnt_q;
  assign dtrial = {rem_q, quo_q[DQ_W-1]};
  assign dge = dtrial >= {1'b0, seg_q};
  assign prod_abs = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
  assign pos_sum = $signed(DQ_W'(axis_q ? s_y_q : s_x_q)) * 0
                 + (DQ_W+2)'(axis_q ? s_y_q : s_x_q)
                 + (neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q}));
  assign pos_sat = (pos_sum > (DQ_W+2)'(8388607)) ? 24'sh7FFFFF :
                   (pos_sum < -(DQ_W+2)'(8388608)) ? 24'sh800000 : pos_sum[COORD_W-1:0];
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    rd_addr = '0;
    mul_a   = '0;
    mul_b   = '0;
    wr_en   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          case (func_e'(in_i.func))
            FUNC_APPEND: begin
              if (n_q < NW'(MAX_VERTICES)) begin
                state_d = ST_AMULX;
              end
            end
            FUNC_PLACE: state_d = (n_q == '0) ? ST_OUT : ST_PSTART;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_AMULX: begin
        mul_a   = app_dx;
        mul_b   = D_W'(app_dx);
        state_d = ST_AMULY;
      end
      ST_AMULY: begin
        mul_a   = app_dy;
        mul_b   = D_W'(app_dy);
        state_d = ST_ASQLD;
      end
      ST_ASQLD: state_d = ST_ASQRT;
      ST_ASQRT: begin
        if (sbit_q == '0) begin
          state_d = ST_AWR;
        end
      end
      ST_AWR: begin
        wr_en   = 1'b1;
        state_d = ST_IDLE;
      end
      ST_PSTART: begin
        if (n_q == NW'(1)) begin
          state_d = ST_SINGLE;
        end else if (d_q < 0 || d_q >= tot33) begin
          state_d = ST_FETCH1;
        end else begin
          state_d = ST_SEARCH;
        end
      end
      ST_SINGLE: state_d = ST_OUT;
      ST_SEARCH: begin
        if (i_q == i_end) begin
          state_d = ST_FETCH1;
        end else begin
          rd_addr = AW'(i_q + AW'(1));
          state_d = ST_SCMP;
        end
      end
      ST_SCMP: state_d = ($signed({1'b0, rd_arc_q}) <= d_q) ? ST_SEARCH : ST_FETCH1;
      ST_FETCH1: begin
        rd_addr = AW'(i_q + AW'(1));
        state_d = ST_FETCH0;
      end
      ST_FETCH0: begin
        rd_addr = i_q;
        state_d = ST_CALC;
      end
      ST_CALC: state_d = ST_SETUP;
      ST_SETUP: state_d = (off_q == '0 || seg_q == '0) ? ST_WANG : ST_MUL;
      ST_MUL: begin
        mul_a   = axis_q ? ddy_q : ddx_q;
        mul_b   = off_q;
        state_d = ST_DLOAD;
      end
      ST_DLOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (dcnt_q == 6'(DQ_W - 1)) begin
          state_d = ST_DEND;
        end
      end
      ST_DEND: state_d = axis_q ? ST_WANG : ST_MUL;
      ST_WANG: begin
        if (cordic_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = is_last ? ST_IDLE : ST_PSTART;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      wcount_q    <= WCNT_W'(1);
      pitch_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE && in_i.valid && func_e'(in_i.func) == FUNC_CLEAR) begin
        n_q <= '0;
      end else if (state_q == ST_AWR) begin
        n_q <= n_q + NW'(1);
      end
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_WAGON_COUNT: wcount_q <= cfg_i.data[WCNT_W-1:0];
          CFG_WAGON_PITCH: pitch_q <= cfg_i.data[PITCH_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_x_q   <= x_mem[rd_addr];
    rd_y_q   <= y_mem[rd_addr];
    rd_arc_q <= arc_mem[rd_addr];
    if (wr_en) begin
      x_mem[n_q[AW-1:0]]   <= ax_q;
      y_mem[n_q[AW-1:0]]   <= ay_q;
      arc_mem[n_q[AW-1:0]] <= arc_new;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        ax_q        <= in_i.pos_x;
        ay_q        <= in_i.pos_y;
        k_q         <= '0;
        res_x_q     <= '0;
        res_y_q     <= '0;
        res_ang_q   <= '0;
        res_empty_q <= (n_q == '0);
        if (head33 > tot33) begin
          d_q <= tot33;
        end else if (head33 < 0) begin
          d_q <= '0;
        end else begin
          d_q <= head33;
        end
        if (n_q == '0 || wcount_q == '0) begin
          cnt_q <= CW'(1);
        end else if (32'(wcount_q) > MAX_WAGONS) begin
          cnt_q <= CW'(MAX_WAGONS);
        end else begin
          cnt_q <= CW'(wcount_q);
        end
      end
      ST_AMULX: prod_q <= prod;
      ST_AMULY: begin
        sq_q   <= prod_q[SQ_W-1:0];
        prod_q <= prod;
      end
      ST_ASQLD: begin
        rad_q  <= sq_q + prod_q[SQ_W-1:0];
        sres_q <= '0;
        sbit_q <= SQ_W'(1) << (SQ_W - 1);
      end
      ST_ASQRT: begin
        if (sbit_q != '0) begin
          if ({1'b0, rad_q} >= strial) begin
            rad_q  <= SQ_W'({1'b0, rad_q} - strial);
            sres_q <= (sres_q >> 1) + sbit_q;
          end else begin
            sres_q <= sres_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
        end
      end
      ST_AWR: begin
        total_q  <= arc_new;
        last_x_q <= ax_q;
        last_y_q <= ay_q;
      end
      ST_PSTART: begin
        if (d_q >= tot33 && d_q >= 0) begin
          i_q <= i_end;
        end else begin
          i_q <= '0;
        end
      end
      ST_SINGLE: begin
        res_x_q   <= rd_x_q;
        res_y_q   <= rd_y_q;
        res_ang_q <= '0;
      end
      ST_SCMP: begin
        if ($signed({1'b0, rd_arc_q}) <= d_q) begin
          i_q <= AW'(i_q + AW'(1));
        end
      end
      ST_FETCH0: begin
        x1_q <= rd_x_q;
        y1_q <= rd_y_q;
        a1_q <= rd_arc_q;
      end
      ST_CALC: begin
        s_x_q <= rd_x_q;
        s_y_q <= rd_y_q;
        ddx_q <= {x1_q[COORD_W-1], x1_q} - {rd_x_q[COORD_W-1], rd_x_q};
        ddy_q <= {y1_q[COORD_W-1], y1_q} - {rd_y_q[COORD_W-1], rd_y_q};
        seg_q <= 31'(a1_q - rd_arc_q);
        off_q <= d_q - $signed({1'b0, rd_arc_q});
      end
      ST_SETUP: begin
        axis_q  <= 1'b0;
        res_x_q <= s_x_q;
        res_y_q <= s_y_q;
      end
      ST_MUL: prod_q <= prod;
      ST_DLOAD: begin
        neg_q  <= prod_q[PROD_W-1];
        quo_q  <= DQ_W'(prod_abs) + DQ_W'(seg_q >> 1);
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      ST_DIV: begin
        rem_q  <= dge ? 31'(dtrial - {1'b0, seg_q}) : dtrial[30:0];
        quo_q  <= {quo_q[DQ_W-2:0], dge};
        dcnt_q <= dcnt_q + 6'd1;
      end
      ST_DEND: begin
        if (axis_q) begin
          res_y_q <= pos_sat;
        end else begin
          res_x_q <= pos_sat;
        end
        axis_q <= 1'b1;
      end
      ST_WANG: res_ang_q <= cordic_rsp.angle;
      ST_OUT: begin
        if (out_load) begin
          k_q <= k_q + CW'(1);
          d_q <= d_q - $signed(D_W'(pitch_q));
          out_o.wagon_index <= IDX_W'(k_q);
          out_o.wagon_x     <= res_x_q;
          out_o.wagon_y     <= res_y_q;
          out_o.angle       <= res_ang_q;
          out_o.empty_res   <= res_empty_q;
          out_o.last        <= is_last;
        end
      end
      default: ;
    endcase
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;

  `PTP_ASSERT_NOW(a_vertex_bound, n_q <= NW'(MAX_VERTICES), "vertex count beyond capacity")
  `PTP_ASSERT_IMPL(a_empty_single, out_o.valid && out_o.empty_res, out_o.last && out_o.wagon_index == '0, "empty path result is not a lone last result")
  `PTP_ASSERT_NEXT(a_last_idle, out_load && is_last, in_i.ready, "not ready after the final wagon")
  `PTP_ASSERT_IMPL(a_div_rem, state_q == ST_DEND, rem_q < seg_q, "division remainder not below the segment length")

endmodule
